@@ sv/blake2sp_hash_engine_core_assert.svh @@
// assertion macros shared by the blake2sp engine modules
// expects a clock named clk and an active-high reset named rst in scope
`ifndef BLAKE2SP_HASH_ENGINE_CORE_ASSERT_SVH
`define BLAKE2SP_HASH_ENGINE_CORE_ASSERT_SVH

// property must hold at every edge outside reset
`define BLK2SP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define BLK2SP_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ sv/blk2sp_pkg.sv @@
// shared types, constants and init values for the blake2sp engine
// no dependencies
package blk2sp_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] hash_t;
  typedef logic [15:0][31:0] block_t;

  // one queued input transfer after byte-count clamping
  typedef struct packed {
    word_t      data;
    logic [2:0] nbytes;
    logic       last;
  } item_t;

  // compression job handed to the compression unit
  typedef struct packed {
    hash_t       h;
    block_t      m;
    logic [63:0] t;
    logic        fin;
    logic        last;
  } cmp_req_t;

  localparam hash_t IV = {32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
                          32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

  localparam word_t PARAM_W0      = 32'h02080020;
  localparam word_t PARAM_W3_LEAF = 32'h20000000;
  localparam word_t PARAM_W3_ROOT = 32'h00010000;

  localparam int HALF_STEPS = 160;

  localparam logic [3:0] SIGMA [0:159] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
    4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
    4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3,
    4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
    4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4,
    4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
    4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8,
    4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
    4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13,
    4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
    4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9,
    4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
    4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11,
    4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
    4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10,
    4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
    4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5,
    4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
    4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0
  };

  function automatic hash_t leaf_init(logic [2:0] idx);
    hash_t h;
    h = IV;
    h[0] = h[0] ^ PARAM_W0;
    h[2] = h[2] ^ {29'd0, idx};
    h[3] = h[3] ^ PARAM_W3_LEAF;
    return h;
  endfunction

  function automatic hash_t root_init();
    hash_t h;
    h = IV;
    h[0] = h[0] ^ PARAM_W0;
    h[3] = h[3] ^ PARAM_W3_LEAF ^ PARAM_W3_ROOT;
    return h;
  endfunction

endpackage

@@ sv/blk2sp_front.sv @@
// input side: takes stream transfers, clamps the byte count, queues items
// depends on blk2sp_pkg
module blk2sp_front #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  blk2sp_pkg::word_t  in_data,
  input  logic [2:0]         in_bytes,
  input  logic               in_last,
  output logic               q_valid,
  input  logic               q_ready,
  output blk2sp_pkg::item_t  q_item
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  blk2sp_pkg::item_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;
  blk2sp_pkg::item_t item_in;

  assign in_ready = (count != CW'(DEPTH));
  assign q_valid  = (count != '0);
  assign q_item   = mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    item_in.data   = in_data;
    item_in.nbytes = (in_bytes > 3'd4) ? 3'd4 : in_bytes;
    item_in.last   = in_last;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ sv/blk2sp_compress.sv @@
// blake2s compression unit, one half mixing step per cycle
// depends on blk2sp_pkg
module blk2sp_compress (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  blk2sp_pkg::cmp_req_t  req,
  output logic                  busy,
  output logic                  done,
  output blk2sp_pkg::hash_t     hash_out
);

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIN} cstate_t;

  cstate_t state;
  logic [7:0] step;
  blk2sp_pkg::hash_t  hreg;
  blk2sp_pkg::block_t mreg;
  blk2sp_pkg::block_t v;
  blk2sp_pkg::block_t vn;
  blk2sp_pkg::block_t vrot;
  blk2sp_pkg::block_t vinit;
  blk2sp_pkg::word_t  w, a1, d1, d2, c1, b1, b2;
  logic       half;
  logic [2:0] g;
  logic [1:0] rot [4];

  assign half = step[0];
  assign g    = step[3:1];
  assign busy = (state != C_IDLE);

  // working words sit in rows of four; the active column is always column 0
  always_comb begin
    w  = mreg[blk2sp_pkg::SIGMA[step]];
    a1 = v[0] + v[4] + w;
    d1 = v[12] ^ a1;
    d2 = half ? {d1[7:0], d1[31:8]} : {d1[15:0], d1[31:16]};
    c1 = v[8] + d2;
    b1 = v[4] ^ c1;
    b2 = half ? {b1[6:0], b1[31:7]} : {b1[11:0], b1[31:12]};
    vn     = v;
    vn[0]  = a1;
    vn[4]  = b2;
    vn[8]  = c1;
    vn[12] = d2;
  end

  // after a full g step shift rows; at the column/diagonal switches skew them
  always_comb begin
    logic [1:0] sel;
    for (int r = 0; r < 4; r++) begin
      if (!half) begin
        rot[r] = 2'd0;
      end else if (g == 3'd3) begin
        rot[r] = 2'(r + 1);
      end else if (g == 3'd7) begin
        rot[r] = 2'(1 - r);
      end else begin
        rot[r] = 2'd1;
      end
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        sel = 2'(c) + rot[r];
        vrot[4*r + c] = vn[{2'(r), sel}];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      vinit[i]     = req.h[i];
      vinit[i + 8] = blk2sp_pkg::IV[i];
    end
    vinit[12] = vinit[12] ^ req.t[31:0];
    vinit[13] = vinit[13] ^ req.t[63:32];
    if (req.fin) begin
      vinit[14] = ~vinit[14];
    end
    if (req.fin && req.last) begin
      vinit[15] = ~vinit[15];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (start) begin
            hreg  <= req.h;
            mreg  <= req.m;
            v     <= vinit;
            step  <= '0;
            state <= C_RUN;
          end
        end
        C_RUN: begin
          v <= vrot;
          if (step == 8'(blk2sp_pkg::HALF_STEPS - 1)) begin
            state <= C_FIN;
          end else begin
            step <= step + 8'd1;
          end
        end
        C_FIN: begin
          for (int i = 0; i < 8; i++) begin
            hash_out[i] <= hreg[i] ^ v[i] ^ v[i + 8];
          end
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

@@ sv/blk2sp_back.sv @@
// work side: byte packing into leaf blocks, leaf and root sequencing, digest output
// depends on blk2sp_pkg and the assertion macro header
`include "blake2sp_hash_engine_core_assert.svh"

module blk2sp_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  blk2sp_pkg::item_t     item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output blk2sp_pkg::word_t     out_word,
  output logic [2:0]            out_index,
  output logic                  out_final,
  output logic                  cmp_start,
  output blk2sp_pkg::cmp_req_t  cmp_req,
  input  logic                  cmp_busy,
  input  logic                  cmp_done,
  input  blk2sp_pkg::hash_t     cmp_hash
);

  typedef enum logic [2:0] {
    S_IDLE, S_BYTE, S_LOAD, S_CSTART, S_CWAIT, S_RSTART, S_RWAIT, S_OUT
  } state_t;

  state_t state;
  blk2sp_pkg::item_t cur_item;
  logic [1:0]  bidx;
  logic [63:0] msg;
  logic [6:0]  fill [8];
  logic [63:0] count [8];
  blk2sp_pkg::hash_t chain [8];
  logic [7:0]  chain_valid;
  blk2sp_pkg::hash_t root_chain;
  blk2sp_pkg::hash_t rbuf;
  blk2sp_pkg::block_t mbuf;
  logic [4:0]  ld;
  logic [2:0]  cur_leaf;
  logic        fin_mode;
  blk2sp_pkg::word_t asm_word;
  logic [2:0]  outk;

  blk2sp_pkg::word_t blk_mem [128];
  blk2sp_pkg::word_t rdata;
  logic [6:0]  rd_addr;
  logic        wr_en;
  logic [6:0]  wr_addr;
  blk2sp_pkg::word_t wr_data;

  logic [2:0]  slot;
  logic [2:0]  leaf_sel;
  logic [6:0]  fill_sel;
  logic        leaf_full;
  logic [7:0]  byte_in;
  logic [4:0]  word_lim;
  logic [3:0]  ld_word;
  logic [63:0] t_leaf;
  logic        item_done;

  assign slot      = msg[8:6];
  assign leaf_sel  = (state == S_BYTE) ? slot : cur_leaf;
  assign fill_sel  = fill[leaf_sel];
  assign leaf_full = fill_sel[6];
  assign byte_in   = cur_item.data[{bidx, 3'b000} +: 8];
  assign item_done = ({1'b0, bidx} + 3'd1 == cur_item.nbytes);
  assign ld_word   = ld[3:0] - 4'd1;
  // words past the fill read as zero
  assign word_lim  = 5'((8'(fill_sel) + 8'd3) >> 2);
  assign t_leaf    = fin_mode ? count[cur_leaf] + {57'd0, fill_sel}
                              : count[cur_leaf] + 64'd64;
  assign rd_addr   = {cur_leaf, ld[3:0]};

  assign item_ready = (state == S_IDLE);
  assign out_valid  = (state == S_OUT);
  assign out_word   = root_chain[outk];
  assign out_index  = outk;
  assign out_final  = (outk == 3'd7);
  assign cmp_start  = (state == S_CSTART) || (state == S_RSTART);

  always_comb begin
    wr_en   = (state == S_BYTE) && !leaf_full;
    wr_addr = {slot, fill_sel[5:2]};
    if (fill_sel[1:0] == 2'd0) begin
      wr_data = {24'd0, byte_in};
    end else begin
      wr_data = asm_word | (blk2sp_pkg::word_t'(byte_in) << {fill_sel[1:0], 3'b000});
    end
  end

  always_comb begin
    if (state == S_RSTART) begin
      cmp_req.h    = root_chain;
      cmp_req.m    = {cmp_hash, rbuf};
      cmp_req.t    = {55'd0, ({1'b0, cur_leaf} + 4'd1), 5'd0};
      cmp_req.fin  = (cur_leaf == 3'd7);
      cmp_req.last = (cur_leaf == 3'd7);
    end else begin
      cmp_req.h    = chain_valid[cur_leaf] ? chain[cur_leaf]
                                           : blk2sp_pkg::leaf_init(cur_leaf);
      cmp_req.m    = mbuf;
      cmp_req.t    = t_leaf;
      cmp_req.fin  = fin_mode;
      cmp_req.last = fin_mode && (cur_leaf == 3'd7);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      blk_mem[wr_addr] <= wr_data;
    end
    rdata <= blk_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      msg         <= '0;
      chain_valid <= '0;
      root_chain  <= blk2sp_pkg::root_init();
      bidx        <= '0;
      ld          <= '0;
      cur_leaf    <= '0;
      fin_mode    <= 1'b0;
      outk        <= '0;
      for (int i = 0; i < 8; i++) begin
        fill[i]  <= '0;
        count[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            cur_item <= item;
            bidx     <= '0;
            if (item.nbytes != 3'd0) begin
              state <= S_BYTE;
            end else if (item.last) begin
              cur_leaf <= '0;
              fin_mode <= 1'b1;
              ld       <= '0;
              state    <= S_LOAD;
            end
          end
        end
        S_BYTE: begin
          if (leaf_full) begin
            // a further byte proves the pending block is not final
            cur_leaf <= slot;
            fin_mode <= 1'b0;
            ld       <= '0;
            state    <= S_LOAD;
          end else begin
            asm_word   <= wr_data;
            fill[slot] <= fill_sel + 7'd1;
            msg        <= msg + 64'd1;
            bidx       <= bidx + 2'd1;
            if (item_done) begin
              if (cur_item.last) begin
                cur_leaf <= '0;
                fin_mode <= 1'b1;
                ld       <= '0;
                state    <= S_LOAD;
              end else begin
                state <= S_IDLE;
              end
            end
          end
        end
        S_LOAD: begin
          if (ld != 5'd0) begin
            mbuf[ld_word] <= ({1'b0, ld_word} < word_lim) ? rdata : '0;
          end
          if (ld == 5'd16) begin
            state <= S_CSTART;
          end else begin
            ld <= ld + 5'd1;
          end
        end
        S_CSTART: begin
          count[cur_leaf] <= t_leaf;
          state           <= S_CWAIT;
        end
        S_CWAIT: begin
          if (cmp_done) begin
            chain[cur_leaf]       <= cmp_hash;
            chain_valid[cur_leaf] <= 1'b1;
            if (!fin_mode) begin
              fill[cur_leaf] <= '0;
              state          <= S_BYTE;
            end else if (!cur_leaf[0]) begin
              rbuf     <= cmp_hash;
              cur_leaf <= cur_leaf + 3'd1;
              ld       <= '0;
              state    <= S_LOAD;
            end else begin
              state <= S_RSTART;
            end
          end
        end
        S_RSTART: begin
          state <= S_RWAIT;
        end
        S_RWAIT: begin
          if (cmp_done) begin
            root_chain <= cmp_hash;
            if (cur_leaf == 3'd7) begin
              outk  <= '0;
              state <= S_OUT;
            end else begin
              cur_leaf <= cur_leaf + 3'd1;
              ld       <= '0;
              state    <= S_LOAD;
            end
          end
        end
        S_OUT: begin
          if (out_ready) begin
            if (outk == 3'd7) begin
              // back to the initial hashing state for the next message
              msg         <= '0;
              chain_valid <= '0;
              root_chain  <= blk2sp_pkg::root_init();
              fin_mode    <= 1'b0;
              for (int i = 0; i < 8; i++) begin
                fill[i]  <= '0;
                count[i] <= '0;
              end
              state <= S_IDLE;
            end else begin
              outk <= outk + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BLK2SP_ASSERT(a_start_when_free, cmp_start |-> !cmp_busy, "compression started while busy")
  `BLK2SP_ASSERT(a_done_awaited, cmp_done |-> (state == S_CWAIT || state == S_RWAIT), "unexpected compression result")
  `BLK2SP_ASSERT(a_byte_counted, (state == S_BYTE && !leaf_full) |=> (msg == $past(msg) + 64'd1), "byte not counted")
  `BLK2SP_ASSERT_NEVER(a_fill_range, fill_sel > 7'd64, "leaf fill beyond one block")

endmodule

@@ sv/blake2sp_hash_engine_core.sv @@
// BLAKE2sp-256 engine, unkeyed, 32-byte digest.
// Input stream: s_axis_tdata carries a little-endian message word and its
// valid byte count (4 on all but the last transfer, counts above 4 act as 4);
// s_axis_tlast marks the last transfer of a message and starts finalization.
// Output stream: eight root digest words, index 0 first, m_axis_tlast on the
// eighth. A four-entry input queue lets the sender run ahead of the hashing.
// Each transfer is taken from the queue and its bytes are packed one at a
// time. Every 64-byte chunk that turns out not to be final costs one leaf
// compression (a block read from the leaf buffer memory plus 160 half mixing
// steps in the one compression unit), and no new transfer is taken from the
// queue while it runs.
// Finalization runs eight leaf and four root compressions before the first
// digest word shows; a stalled receiver holds the current word and the engine
// waits. After the eighth word is taken the engine is back in its initial
// state. Reset (rst, synchronous) empties the queue and discards any partial
// message; there is no clearing pass.
// depends on blk2sp_pkg, blk2sp_front, blk2sp_compress, blk2sp_back
module blake2sp_hash_engine_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // data_word[31:0], bytes_valid[34:32], zero
  input  logic        s_axis_tlast,   // message_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // digest_word[31:0], word_index[34:32], zero
  output logic        m_axis_tlast    // final_word
);

  logic                  q_valid;
  logic                  q_ready;
  blk2sp_pkg::item_t     q_item;
  logic                  cmp_start;
  logic                  cmp_busy;
  logic                  cmp_done;
  blk2sp_pkg::cmp_req_t  cmp_req;
  blk2sp_pkg::hash_t     cmp_hash;
  blk2sp_pkg::word_t     out_word;
  logic [2:0]            out_index;

  blk2sp_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata[31:0]),
    .in_bytes (s_axis_tdata[34:32]),
    .in_last  (s_axis_tlast),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  blk2sp_compress u_compress (
    .clk      (clk),
    .rst      (rst),
    .start    (cmp_start),
    .req      (cmp_req),
    .busy     (cmp_busy),
    .done     (cmp_done),
    .hash_out (cmp_hash)
  );

  blk2sp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_word   (out_word),
    .out_index  (out_index),
    .out_final  (m_axis_tlast),
    .cmp_start  (cmp_start),
    .cmp_req    (cmp_req),
    .cmp_busy   (cmp_busy),
    .cmp_done   (cmp_done),
    .cmp_hash   (cmp_hash)
  );

  assign m_axis_tdata = {5'd0, out_index, out_word};

endmodule

@@ bench/tb_blake2sp_hash_engine_core.sv @@
// testbench for blake2sp_hash_engine_core: streams messages, predicts root digests
// with a behavioral blake2sp model and checks every digest word; needs blk2sp_pkg
module tb_blake2sp_hash_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef bit [31:0] w8_t[8];
  typedef bit [31:0] w16_t[16];

  class digest_scoreboard;
    w8_t leaf_h[8];
    w16_t leaf_m[8];
    int leaf_fill[8];
    bit [63:0] leaf_bytes[8];
    bit [63:0] msg_bytes;
    bit [35:0] digest_q[$];   // {final, index, word}
    int errors;

    function new();
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) begin
        for (int j = 0; j < 8; j++) leaf_h[i][j] = blk2sp_pkg::IV[j];
        leaf_h[i][0] ^= blk2sp_pkg::PARAM_W0;
        leaf_h[i][2] ^= 32'(i);
        leaf_h[i][3] ^= blk2sp_pkg::PARAM_W3_LEAF;
        for (int j = 0; j < 16; j++) leaf_m[i][j] = '0;
        leaf_fill[i] = 0;
        leaf_bytes[i] = '0;
      end
      msg_bytes = '0;
    endfunction

    function bit [31:0] ror(bit [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void crunch(inout w8_t h, input w16_t m, input bit [63:0] t,
                         input bit fin, input bit lastnode);
      int ga[8] = '{0, 1, 2, 3, 0, 1, 2, 3};
      int gb[8] = '{4, 5, 6, 7, 5, 6, 7, 4};
      int gc[8] = '{8, 9, 10, 11, 10, 11, 8, 9};
      int gd[8] = '{12, 13, 14, 15, 15, 12, 13, 14};
      bit [31:0] v[16];
      bit [31:0] x, y;
      int a, b, c, d;
      for (int i = 0; i < 8; i++) begin
        v[i] = h[i];
        v[i + 8] = blk2sp_pkg::IV[i];
      end
      v[12] ^= t[31:0];
      v[13] ^= t[63:32];
      if (fin) v[14] = ~v[14];
      if (fin && lastnode) v[15] = ~v[15];
      for (int r = 0; r < 10; r++) begin
        for (int j = 0; j < 8; j++) begin
          a = ga[j]; b = gb[j]; c = gc[j]; d = gd[j];
          x = m[blk2sp_pkg::SIGMA[r * 16 + 2 * j]];
          y = m[blk2sp_pkg::SIGMA[r * 16 + 2 * j + 1]];
          v[a] = v[a] + v[b] + x;
          v[d] = ror(v[d] ^ v[a], 16);
          v[c] = v[c] + v[d];
          v[b] = ror(v[b] ^ v[c], 12);
          v[a] = v[a] + v[b] + y;
          v[d] = ror(v[d] ^ v[a], 8);
          v[c] = v[c] + v[d];
          v[b] = ror(v[b] ^ v[c], 7);
        end
      end
      for (int i = 0; i < 8; i++) h[i] ^= v[i] ^ v[i + 8];
    endfunction

    function void absorb_byte(bit [7:0] bt);
      int slot, f;
      slot = msg_bytes[8:6];
      // a full block is only compressed once a further byte arrives
      if (leaf_fill[slot] >= 64) begin
        leaf_bytes[slot] += 64;
        crunch(leaf_h[slot], leaf_m[slot], leaf_bytes[slot], 0, 0);
        leaf_fill[slot] = 0;
      end
      f = leaf_fill[slot];
      if (f % 4 == 0) leaf_m[slot][f / 4] = {24'd0, bt};
      else leaf_m[slot][f / 4][8 * (f % 4) +: 8] = bt;
      leaf_fill[slot] = f + 1;
      msg_bytes += 1;
    endfunction

    function void note_transfer(bit [31:0] data, bit [2:0] nb, bit endmsg);
      w8_t root_h;
      w16_t root_m;
      int n, rfill;
      bit [63:0] root_bytes;
      n = (nb > 4) ? 4 : nb;
      for (int i = 0; i < n; i++) absorb_byte(data[8 * i +: 8]);
      if (!endmsg) return;
      for (int j = 0; j < 8; j++) root_h[j] = blk2sp_pkg::IV[j];
      root_h[0] ^= blk2sp_pkg::PARAM_W0;
      root_h[3] ^= blk2sp_pkg::PARAM_W3_LEAF | blk2sp_pkg::PARAM_W3_ROOT;
      for (int j = 0; j < 16; j++) root_m[j] = '0;
      root_bytes = '0;
      rfill = 0;
      for (int i = 0; i < 8; i++) begin
        leaf_bytes[i] += leaf_fill[i];
        for (int f = leaf_fill[i]; f < 64; f++) leaf_m[i][f / 4][8 * (f % 4) +: 8] = 8'd0;
        crunch(leaf_h[i], leaf_m[i], leaf_bytes[i], 1, i == 7);
        for (int k = 0; k < 8; k++) begin
          if (rfill >= 16) begin
            root_bytes += 64;
            crunch(root_h, root_m, root_bytes, 0, 0);
            rfill = 0;
          end
          root_m[rfill] = leaf_h[i][k];
          rfill++;
        end
      end
      root_bytes += 4 * rfill;
      crunch(root_h, root_m, root_bytes, 1, 1);
      for (int k = 0; k < 8; k++) digest_q.push_back({k == 7, 3'(k), root_h[k]});
      restart();
    endfunction

    function void check_word(bit [31:0] word, bit [2:0] idx, bit fin);
      bit [35:0] exp;
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest transfer word=%h index=%0d final=%0b",
                 $time, word, idx, fin);
        errors++;
        return;
      end
      exp = digest_q.pop_front();
      if (exp[31:0] !== word) begin
        $display("%0t: digest_word expected %h actual %h", $time, exp[31:0], word);
        errors++;
      end
      if (exp[34:32] !== idx) begin
        $display("%0t: word_index expected %0d actual %0d", $time, exp[34:32], idx);
        errors++;
      end
      if (exp[35] !== fin) begin
        $display("%0t: final_word expected %0b actual %0b", $time, exp[35], fin);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic s_axis_tlast = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [39:0] m_axis_tdata;
  logic m_axis_tlast;

  digest_scoreboard sb = new();
  int items_sent;
  bit send_busy;
  bit recv_busy;

  always #2 clk = ~clk;

  blake2sp_hash_engine_core dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  function automatic int pick_gap(bit busy);
    int r;
    if (!busy) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // entered at a falling edge, returns at a falling edge
  task automatic send_item(bit [31:0] data, bit [2:0] nb, bit endmsg);
    int gap;
    s_axis_tvalid <= 1;
    s_axis_tdata <= {5'd0, nb, data};
    s_axis_tlast <= endmsg;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_transfer(data, nb, endmsg);
    items_sent++;
    @(negedge clk);
    gap = pick_gap(send_busy);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_message(int nwords, bit odd_counts);
    bit [2:0] nb;
    send_busy = $urandom_range(0, 3) != 0;
    for (int i = 0; i < nwords; i++) begin
      nb = (odd_counts && $urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
      send_item($urandom, nb, 0);
    end
    send_item($urandom, 3'($urandom_range(0, 7)), 1);
  endtask

  // receiver: random stalls, with calm stretches
  initial begin
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) recv_busy = !recv_busy;
      m_axis_tready <= (pick_gap(recv_busy) == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_word(m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast);
  end

  initial begin
    #25000000;
    $display("tb_blake2sp_hash_engine_core failed");
    $finish;
  end

  initial begin
    int wait_cycles;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(negedge clk);
    // empty message, all-ones word, excess count on a zero word
    send_busy = 0;
    send_item(32'h0, 3'd0, 1);
    send_item(32'hffffffff, 3'd4, 1);
    send_item(32'h0, 3'd7, 1);
    // unaligned stream from short non-final items
    send_item(32'h11223344, 3'd1, 0);
    send_item(32'haabbccdd, 3'd2, 0);
    send_item(32'h55667788, 3'd3, 0);
    send_item(32'hdeadbeef, 3'd5, 0);
    send_item(32'h01234567, 3'd6, 1);
    // exactly one full block stays pending until the empty last item
    send_busy = 1;
    for (int i = 0; i < 16; i++) send_item($urandom, 3'd4, 0);
    send_item($urandom, 3'd0, 1);
    recv_busy = 1;
    while (items_sent < 450) begin
      if ($urandom_range(0, 9) == 0) send_message($urandom_range(129, 170), 1);
      else send_message($urandom_range(0, 30), $urandom_range(0, 1));
    end
    s_axis_tvalid <= 0;
    recv_busy = 0;
    wait_cycles = 0;
    while (sb.digest_q.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.digest_q.size() == 0)
      $display("tb_blake2sp_hash_engine_core passed");
    else
      $display("tb_blake2sp_hash_engine_core failed");
    $finish;
  end
endmodule
